// ===== design/assert_macros.svh =====
// Assertion helper macros for the console RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tcc_pkg.sv =====
// Shared constants, types and controller/datapath command structs for the
// text console cursor writer. No dependencies.
`timescale 1ns / 1ps

package tcc_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // Field widths
    localparam int OPCODE_W = 1;
    localparam int CHAR_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int COL_W    = 7;
    localparam int ROW_W    = 5;
    localparam int CELL_W   = 16;
    localparam int ATTR_W   = 8;

    // Screen store addressing and clear counter
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
    localparam int                TAB_STOP   = 8;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_PUT  = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR,
        ST_RESP
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic clr_step;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scroll_now;
        logic clr_last;
    } t_dp_status;

endpackage

// ===== design/tcc_if.sv =====
// Valid/ready channel interfaces for console items and results.
// Depends on tcc_pkg for field widths.
`timescale 1ns / 1ps

interface tcc_in_if import tcc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [CHAR_W-1:0]   char_code;
    logic [INDEX_W-1:0]  cell_index;

    modport source (output valid, output opcode, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input opcode, input char_code, input cell_index,
                    output ready);
endinterface

interface tcc_out_if import tcc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              scrolled;
    logic [CELL_W-1:0] cell_value;

    modport source (output valid, output cursor_col, output cursor_row, output scrolled,
                    output cell_value, input ready);
    modport sink   (input valid, input cursor_col, input cursor_row, input scrolled,
                    input cell_value, output ready);
endinterface

// ===== design/text_console_cursor_writer_core.sv =====
// Top level of the text console cursor writer: controller plus datapath.
// Depends on tcc_pkg, tcc_if, tcc_ctrl and tcc_datapath.
`timescale 1ns / 1ps

// Text console engine, 80 x 25 cells of 16 bits (attribute high, character
// low). Put items interpret newline, carriage return and tab, and write any
// other byte at the cursor; read items return one cell (0 past the end).
// Each item is accepted, then executed, then handed to the result slot once free.
// A put that scrolls adds a row clear: the screen scrolls by moving a top-row
// base pointer, and the vacated row is rewritten with 0x0720 one cell per
// cycle through the store's single write port. After reset a clearing
// pass blanks the store; no item is accepted until it finishes, while
// attribute writes are taken at any time.
module text_console_cursor_writer_core import tcc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [ATTR_W-1:0] i_cfg_wr_data,
    tcc_in_if.sink            i_item,
    tcc_out_if.source         o_result
);

    t_dp_cmd    cmd;
    t_dp_status st;

    tcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    tcc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_opcode      (i_item.opcode),
        .i_char_code   (i_item.char_code),
        .i_cell_index  (i_item.cell_index),
        .i_cmd         (cmd),
        .o_st          (st),
        .o_cursor_col  (o_result.cursor_col),
        .o_cursor_row  (o_result.cursor_row),
        .o_scrolled    (o_result.scrolled),
        .o_cell_value  (o_result.cell_value)
    );

endmodule

// ===== design/tcc_datapath.sv =====
// Datapath: screen store, cursor, rotating top-row base, clear sweep and
// result register. Depends on tcc_pkg; driven by tcc_ctrl commands.
`timescale 1ns / 1ps

module tcc_datapath import tcc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [ATTR_W-1:0]   i_cfg_wr_data,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [CHAR_W-1:0]   i_char_code,
    input  logic [INDEX_W-1:0]  i_cell_index,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_st,
    output logic [COL_W-1:0]    o_cursor_col,
    output logic [ROW_W-1:0]    o_cursor_row,
    output logic                o_scrolled,
    output logic [CELL_W-1:0]   o_cell_value
);

    logic [CELL_W-1:0]   r_mem [CELLS];
    logic [CELL_W-1:0]   r_rd_data;

    logic [ATTR_W-1:0]   r_attr;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic [ADDR_W-1:0]   r_base;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [CNT_W-1:0]    r_clr_cnt;
    logic                r_scroll;

    logic [OPCODE_W-1:0] r_op;
    logic [CHAR_W-1:0]   r_char;
    logic                r_rd_oor;

    logic [COL_W-1:0]    r_out_col;
    logic [ROW_W-1:0]    r_out_row;
    logic                r_out_scroll;
    logic [CELL_W-1:0]   r_out_cell;

    logic                is_read;
    logic                is_lf;
    logic                is_cr;
    logic                is_tab;
    logic                is_print;
    logic [COL_W:0]      col_raw;
    logic                col_wrap;
    logic [ROW_W:0]      row_raw;
    logic                scroll_now;
    logic [COL_W-1:0]    n_col;
    logic [ROW_W-1:0]    n_row;
    logic [ADDR_W-1:0]   lin_addr;
    logic [ADDR_W:0]     wr_sum;
    logic [ADDR_W-1:0]   wr_phys;
    logic [ADDR_W:0]     rd_sum;
    logic                rd_oor;
    logic [ADDR_W-1:0]   rd_phys;
    logic [ADDR_W:0]     base_sum;
    logic [ADDR_W-1:0]   n_base;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [CELL_W-1:0]   wr_data;
    logic                put_exec;

    // Character decode of the captured item
    assign is_read  = (r_op == OP_READ);
    assign is_lf    = (r_char == CH_LF);
    assign is_cr    = (r_char == CH_CR);
    assign is_tab   = (r_char == CH_TAB);
    assign is_print = !is_lf && !is_cr && !is_tab;
    assign put_exec = i_cmd.exec && !is_read;

    // Next cursor position
    always_comb begin
        if (is_lf || is_cr) begin
            col_raw = '0;
        end else if (is_tab) begin
            col_raw = ({1'b0, r_col} + (COL_W+1)'(TAB_STOP))
                      & ~(COL_W+1)'(TAB_STOP - 1);
        end else begin
            col_raw = {1'b0, r_col} + (COL_W+1)'(1);
        end
        col_wrap   = (col_raw >= (COL_W+1)'(COLUMNS));
        row_raw    = {1'b0, r_row} + (ROW_W+1)'(is_lf) + (ROW_W+1)'(col_wrap);
        scroll_now = !is_read && (row_raw >= (ROW_W+1)'(ROWS));
        n_col      = col_wrap ? '0 : col_raw[COL_W-1:0];
        n_row      = scroll_now ? ROW_W'(ROWS - 1) : row_raw[ROW_W-1:0];
    end

    // Cursor to physical address, rotated by the top-row base
    always_comb begin
        lin_addr = ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);
        wr_sum   = {1'b0, lin_addr} + {1'b0, r_base};
        wr_phys  = (wr_sum >= (ADDR_W+1)'(CELLS)) ? ADDR_W'(wr_sum - (ADDR_W+1)'(CELLS))
                                                    : wr_sum[ADDR_W-1:0];
    end

    // Read index to physical address
    always_comb begin
        rd_oor  = ({1'b0, i_cell_index} >= (INDEX_W+1)'(CELLS));
        rd_sum  = (ADDR_W+1)'(i_cell_index) + {1'b0, r_base};
        if (rd_oor) begin
            rd_phys = '0;
        end else if (rd_sum >= (ADDR_W+1)'(CELLS)) begin
            rd_phys = ADDR_W'(rd_sum - (ADDR_W+1)'(CELLS));
        end else begin
            rd_phys = rd_sum[ADDR_W-1:0];
        end
    end

    // Top-row base advances one row per scroll
    always_comb begin
        base_sum = {1'b0, r_base} + (ADDR_W+1)'(COLUMNS);
        n_base   = (base_sum >= (ADDR_W+1)'(CELLS)) ? ADDR_W'(base_sum - (ADDR_W+1)'(CELLS))
                                                      : base_sum[ADDR_W-1:0];
    end

    // Single write port: clear sweep or character write
    assign wr_en   = i_cmd.clr_step || (put_exec && is_print);
    assign wr_addr = i_cmd.clr_step ? r_clr_addr : wr_phys;
    assign wr_data = i_cmd.clr_step ? BLANK_CELL : {r_attr, r_char};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.capture) begin
            r_rd_data <= r_mem[rd_phys];
        end
    end

    // Captured item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_opcode;
            r_char   <= i_char_code;
            r_rd_oor <= rd_oor;
        end
    end

    // Attribute register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_wr_en) begin
            r_attr <= i_cfg_wr_data;
        end
    end

    // Cursor, base and scroll flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_base   <= '0;
            r_scroll <= 1'b0;
        end else if (i_cmd.exec) begin
            r_scroll <= scroll_now;
            if (!is_read) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (scroll_now) begin
                r_base <= n_base;
            end
        end
    end

    // Clear sweep: whole store after reset, vacated row after a scroll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_cnt  <= CNT_W'(CELLS);
        end else if (i_cmd.exec && scroll_now) begin
            r_clr_addr <= r_base;
            r_clr_cnt  <= CNT_W'(COLUMNS);
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            r_clr_cnt  <= r_clr_cnt - CNT_W'(1);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_col    <= put_exec ? n_col : r_col;
            r_out_row    <= put_exec ? n_row : r_row;
            r_out_scroll <= i_cmd.exec ? scroll_now : r_scroll;
            r_out_cell   <= (is_read && !r_rd_oor) ? r_rd_data : '0;
        end
    end

    assign o_st.scroll_now = scroll_now;
    assign o_st.clr_last   = (r_clr_cnt == CNT_W'(1));

    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;
    assign o_scrolled   = r_out_scroll;
    assign o_cell_value = r_out_cell;

endmodule

// ===== design/tcc_ctrl.sv =====
// Controller FSM: sequences capture, execute, row clearing and result
// hand-off. Depends on tcc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcc_ctrl import tcc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_st,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    // Result slot is free when empty or being taken this cycle
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (i_st.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (i_st.scroll_now) n_state = ST_CLEAR;
                else if (out_free)   n_state = ST_IDLE;
                else                 n_state = ST_RESP;
            end
            ST_CLEAR: begin
                if (i_st.clr_last) n_state = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_INIT: begin
                o_cmd.clr_step = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.exec     = 1'b1;
                o_cmd.load_out = !i_st.scroll_now && out_free;
            end
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            ST_RESP: begin
                o_cmd.load_out = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    `ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, o_cmd.load_out, out_free, "result overwritten")
    `ASSERT_NEXT(a_scroll_clears, i_clk, i_rst_n, (r_state == ST_EXEC) && i_st.scroll_now, (r_state == ST_CLEAR), "scroll without row clear")
    `ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, i_in_valid && o_in_ready, (r_state == ST_EXEC), "accepted item not executed")

endmodule
